// File: sv/ima_pkg.sv
// ----------------------------------------------------------------------------
// ima_pkg
// Shared constants, codes and types of the integer matrix engine.
// ----------------------------------------------------------------------------
package ima_pkg;

  // Matrix geometry. The store index is {row, col}, so MAX_DIM is a power of two.
  localparam int MAX_DIM = 8;
  localparam int DIM_W   = $clog2(MAX_DIM);
  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int ADDR_W  = 2 * DIM_W;
  localparam int SIZE_W  = 4;
  localparam int DATA_W  = 32;

  // Input item kinds
  localparam logic [1:0] MODE_LOAD_A  = 2'd0;
  localparam logic [1:0] MODE_LOAD_B  = 2'd1;
  localparam logic [1:0] MODE_COMPUTE = 2'd2;

  // Operations
  localparam logic [1:0] OP_ADD     = 2'd0;
  localparam logic [1:0] OP_PRODUCT = 2'd1;
  localparam logic [1:0] OP_SCALE   = 2'd2;

  // Error codes on the result stream
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_ADD     = 2'd1;
  localparam logic [1:0] ERR_PRODUCT = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_OPERATION = 3'd0;
  localparam logic [2:0] CFG_A_ROWS    = 3'd1;
  localparam logic [2:0] CFG_A_COLS    = 3'd2;
  localparam logic [2:0] CFG_B_ROWS    = 3'd3;
  localparam logic [2:0] CFG_B_COLS    = 3'd4;
  localparam logic [2:0] CFG_SCALE     = 3'd5;

  // Tag that travels with each memory read down the walk pipeline
  typedef struct packed {
    logic [DIM_W-1:0] row;
    logic [DIM_W-1:0] col;
    logic             first;     // first term of the element
    logic             last_k;    // last term of the element
    logic             last_elem; // last element of the run
    logic             zero;      // empty inner sum: term is zero
  } ima_tag_t;

  // Saturate a size register to MAX_DIM
  function automatic logic [SIZE_W-1:0] clamp_dim(input logic [SIZE_W-1:0] d);
    logic [SIZE_W-1:0] lim;
    lim = SIZE_W'(MAX_DIM);
    clamp_dim = (d > lim) ? lim : d;
  endfunction

endpackage

// File: sv/ima_ram.sv
// ----------------------------------------------------------------------------
// ima_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ima_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and register the read word; hold it while rd_en is low
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: sv/integer_matrix_arithmetic.sv
// ----------------------------------------------------------------------------
// integer_matrix_arithmetic
// Integer matrix engine: elementwise add, matrix product or scalar scaling
// over two 8x8 operand stores, results streamed out in row-major order.
//
//   Port group | Direction | Handshake          | Word
//   s_*        | in        | s_tvalid/s_tready  | load A, load B or compute
//   m_*        | out       | m_tvalid/m_tready  | one result element
//   cfg_*      | in        | cfg_valid/cfg_ready| register index and data
//
// A load word is written to its store at the accepting edge.
// A compute word passes the check state, then one memory read per term: one
// read per element for add and scale, inner-size reads per element for the
// product (a single read port on each store feeds one multiply-accumulate),
// then the read, multiply and accumulate stages drain.
// A size mismatch puts its single error word in the output register once free.
// Reset clears control and sets the registers to defaults; the stores are not cleared.
// A result word held by m_tready low freezes the whole walk pipeline,
// memory reads included.
// ----------------------------------------------------------------------------
module integer_matrix_arithmetic (
  input  logic        clk,
  input  logic        rst,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [2:0] row, [5:3] col, [37:6] value, rest zero
  input  logic [1:0]  s_tuser,   // [1:0] mode
  // Result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [2:0] out_row, [5:3] out_col, [37:6] out_value
  output logic        m_tlast,
  output logic [1:0]  m_tuser,   // [1:0] error
  // Configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CHECK = 2'd1;
  localparam logic [1:0] ST_WALK  = 2'd2;
  localparam logic [1:0] ST_DRAIN = 2'd3;

  localparam int DW = ima_pkg::DIM_W;
  localparam int SW = ima_pkg::SIZE_W;
  localparam int XW = ima_pkg::DATA_W;
  localparam int AW = ima_pkg::ADDR_W;

  // Configuration registers
  logic [1:0]    operation;
  logic [SW-1:0] a_rows;
  logic [SW-1:0] a_cols;
  logic [SW-1:0] b_rows;
  logic [SW-1:0] b_cols;
  logic [XW-1:0] scale_factor;

  // Control
  logic [1:0]    state;
  logic [1:0]    state_next;
  logic [DW-1:0] i_cnt, i_next;
  logic [DW-1:0] j_cnt, j_next;
  logic [DW-1:0] k_cnt, k_next;

  logic in_accept;
  logic adv;
  logic issue;
  logic err_load;
  logic [1:0] check_err;
  logic op_known;

  logic [SW-1:0] nr, nc, nk, inner;
  logic zero_inner;
  logic i_last, j_last, k_last;

  // Memory ports
  logic          wr_a, wr_b;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr_a, rd_addr_b;
  logic [XW-1:0] rd_a, rd_b;

  // Pipeline
  logic                 p1_valid, p2_valid;
  ima_pkg::ima_tag_t    issue_tag, p1_tag, p2_tag;
  logic [XW-1:0]        p2_term;
  logic [XW-1:0]        term;
  logic [XW-1:0]        mul_x;
  logic [XW-1:0]        mul_lo;
  logic [XW-1:0]        acc;
  logic [XW-1:0]        sum;

  // Output register
  logic [DW-1:0] o_row, o_col;
  logic [XW-1:0] o_value;
  logic          o_last;
  logic [1:0]    o_err;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign in_accept = s_tvalid && s_tready;
  assign adv       = !m_tvalid || m_tready;
  assign issue     = (state == ST_WALK) && adv;

  // Configuration register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      operation    <= ima_pkg::OP_PRODUCT;
      a_rows       <= SW'(ima_pkg::MAX_DIM);
      a_cols       <= SW'(ima_pkg::MAX_DIM);
      b_rows       <= SW'(ima_pkg::MAX_DIM);
      b_cols       <= SW'(ima_pkg::MAX_DIM);
      scale_factor <= XW'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ima_pkg::CFG_OPERATION: operation    <= cfg_data[1:0];
        ima_pkg::CFG_A_ROWS:    a_rows       <= cfg_data[SW-1:0];
        ima_pkg::CFG_A_COLS:    a_cols       <= cfg_data[SW-1:0];
        ima_pkg::CFG_B_ROWS:    b_rows       <= cfg_data[SW-1:0];
        ima_pkg::CFG_B_COLS:    b_cols       <= cfg_data[SW-1:0];
        ima_pkg::CFG_SCALE:     scale_factor <= cfg_data;
        default: ;
      endcase
    end
  end

  // Result sizes, inner loop length and the mismatch check
  always_comb begin
    inner      = ima_pkg::clamp_dim(a_cols);
    nr         = '0;
    nc         = '0;
    nk         = SW'(1);
    zero_inner = 1'b0;
    check_err  = ima_pkg::ERR_NONE;
    op_known   = 1'b1;
    case (operation)
      ima_pkg::OP_ADD: begin
        nr = ima_pkg::clamp_dim(a_rows);
        nc = ima_pkg::clamp_dim(a_cols);
        if (a_rows != b_rows || a_cols != b_cols) check_err = ima_pkg::ERR_ADD;
      end
      ima_pkg::OP_PRODUCT: begin
        nr         = ima_pkg::clamp_dim(a_rows);
        nc         = ima_pkg::clamp_dim(b_cols);
        zero_inner = (inner == '0);
        nk         = zero_inner ? SW'(1) : inner;
        if (a_cols != b_rows) check_err = ima_pkg::ERR_PRODUCT;
      end
      ima_pkg::OP_SCALE: begin
        nr = ima_pkg::clamp_dim(b_rows);
        nc = ima_pkg::clamp_dim(b_cols);
      end
      default: op_known = 1'b0;
    endcase
  end

  assign i_last = ({1'b0, i_cnt} == SW'(nr - SW'(1)));
  assign j_last = ({1'b0, j_cnt} == SW'(nc - SW'(1)));
  assign k_last = ({1'b0, k_cnt} == SW'(nk - SW'(1)));

  // Sequencer: check, walk the elements and their terms, drain
  always_comb begin
    state_next = state;
    i_next     = i_cnt;
    j_next     = j_cnt;
    k_next     = k_cnt;
    err_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_accept && s_tuser == ima_pkg::MODE_COMPUTE) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (!op_known) begin
          state_next = ST_IDLE;
        end else if (check_err != ima_pkg::ERR_NONE) begin
          if (adv) begin
            err_load   = 1'b1;
            state_next = ST_IDLE;
          end
        end else if (nr == '0 || nc == '0) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_WALK;
          i_next     = '0;
          j_next     = '0;
          k_next     = '0;
        end
      end
      ST_WALK: begin
        if (adv) begin
          if (!k_last) begin
            k_next = k_cnt + DW'(1);
          end else begin
            k_next = '0;
            if (!j_last) begin
              j_next = j_cnt + DW'(1);
            end else begin
              j_next = '0;
              if (i_last) state_next = ST_DRAIN;
              else i_next = i_cnt + DW'(1);
            end
          end
        end
      end
      ST_DRAIN: begin
        if (!p1_valid && !p2_valid) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      i_cnt <= '0;
      j_cnt <= '0;
      k_cnt <= '0;
    end else begin
      state <= state_next;
      i_cnt <= i_next;
      j_cnt <= j_next;
      k_cnt <= k_next;
    end
  end

  // Store writes from load words; read addresses from the walk counters
  assign wr_a    = in_accept && (s_tuser == ima_pkg::MODE_LOAD_A);
  assign wr_b    = in_accept && (s_tuser == ima_pkg::MODE_LOAD_B);
  assign wr_addr = {s_tdata[DW-1:0], s_tdata[2*DW-1:DW]};

  always_comb begin
    if (operation == ima_pkg::OP_PRODUCT) begin
      rd_addr_a = {i_cnt, k_cnt};
      rd_addr_b = {k_cnt, j_cnt};
    end else begin
      rd_addr_a = {i_cnt, j_cnt};
      rd_addr_b = {i_cnt, j_cnt};
    end
  end

  ima_ram #(.WIDTH(XW), .DEPTH(ima_pkg::DEPTH)) u_store_a (
    .clk     (clk),
    .wr_en   (wr_a),
    .wr_addr (wr_addr),
    .wr_data (s_tdata[2*DW+XW-1:2*DW]),
    .rd_en   (issue),
    .rd_addr (rd_addr_a),
    .rd_data (rd_a)
  );

  ima_ram #(.WIDTH(XW), .DEPTH(ima_pkg::DEPTH)) u_store_b (
    .clk     (clk),
    .wr_en   (wr_b),
    .wr_addr (wr_addr),
    .wr_data (s_tdata[2*DW+XW-1:2*DW]),
    .rd_en   (issue),
    .rd_addr (rd_addr_b),
    .rd_data (rd_b)
  );

  // Tag for the read issued this cycle
  always_comb begin
    issue_tag.row       = i_cnt;
    issue_tag.col       = j_cnt;
    issue_tag.first     = (k_cnt == '0);
    issue_tag.last_k    = k_last;
    issue_tag.last_elem = k_last && j_last && i_last;
    issue_tag.zero      = zero_inner;
  end

  // Term: zero for an empty inner sum, sum for add, wrapping product otherwise (low word only)
  assign mul_x  = (operation == ima_pkg::OP_PRODUCT) ? rd_a : scale_factor;
  assign mul_lo = mul_x * rd_b;

  always_comb begin
    if (p1_tag.zero) term = '0;
    else if (operation == ima_pkg::OP_ADD) term = rd_a + rd_b;
    else term = mul_lo;
  end

  // Advance the pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
    end else if (adv) begin
      p1_valid <= issue;
      p2_valid <= p1_valid;
    end
  end

  // Advance the pipeline payload
  always_ff @(posedge clk) begin
    if (adv) begin
      p1_tag  <= issue_tag;
      p2_tag  <= p1_tag;
      p2_term <= term;
    end
  end

  // Accumulate the terms of one element
  assign sum = p2_tag.first ? p2_term : acc + p2_term;

  always_ff @(posedge clk) begin
    if (adv && p2_valid) begin
      acc <= sum;
    end
  end

  // Output register: finished elements and the mismatch word
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((adv && p2_valid && p2_tag.last_k) || err_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (err_load) begin
      o_row   <= '0;
      o_col   <= '0;
      o_value <= '0;
      o_last  <= 1'b1;
      o_err   <= check_err;
    end else if (adv && p2_valid && p2_tag.last_k) begin
      o_row   <= p2_tag.row;
      o_col   <= p2_tag.col;
      o_value <= sum;
      o_last  <= p2_tag.last_elem;
      o_err   <= ima_pkg::ERR_NONE;
    end
  end

  assign m_tdata = {2'b00, o_value, o_col, o_row};
  assign m_tlast = o_last;
  assign m_tuser = o_err;

  // Loads and compute words are taken only with the walk pipeline empty
  assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (!p1_valid && !p2_valid))
    else $error("input taken while walk pipeline busy");

  // A mismatch word is a lone zero word marked last
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != ima_pkg::ERR_NONE) |-> (m_tlast && m_tdata == '0))
    else $error("error word malformed");

  // The final term of the run lands as a last result word
  assert property (@(posedge clk) disable iff (rst)
    (adv && p2_valid && p2_tag.last_k && p2_tag.last_elem) |=> (m_tvalid && m_tlast))
    else $error("final element not marked last");

endmodule

// File: bench/ima_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ima_checker
// Passive monitor for the integer matrix engine. It follows register writes
// and element loads, expands every compute word into the result words the
// engine owes, and compares each result word field by field, oldest first.
// ----------------------------------------------------------------------------
module ima_checker
  import ima_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,   // [2:0] row, [5:3] col, [37:6] value, rest zero
  input  logic [1:0]  s_tuser,   // [1:0] mode
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,   // [2:0] out_row, [5:3] out_col, [37:6] out_value
  input  logic        m_tlast,
  input  logic [1:0]  m_tuser,   // [1:0] error
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          mismatches,
  output int          pending,
  output int          checked,
  output int          error_words
);

  typedef struct packed {
    logic [2:0]  row;
    logic [2:0]  col;
    logic [31:0] value;
    logic        last;
    logic [1:0]  err;
  } result_elem_t;

  // Shadow copies of the operand stores and registers
  logic [31:0] a_store [DEPTH];
  logic [31:0] b_store [DEPTH];
  logic [1:0]  op_r;
  logic [3:0]  a_rows_r, a_cols_r, b_rows_r, b_cols_r;
  logic [31:0] scale_r;

  result_elem_t elems_due[$];
  int           n_mismatch = 0;
  int           n_checked  = 0;
  int           n_err      = 0;

  function automatic logic [3:0] saturate(input logic [3:0] d);
    return (d > 4'd8) ? 4'd8 : d;
  endfunction

  task automatic queue_elem(input logic [2:0] r, input logic [2:0] c,
                            input logic [31:0] v, input logic lst,
                            input logic [1:0] e);
    result_elem_t el;
    el.row   = r;
    el.col   = c;
    el.value = v;
    el.last  = lst;
    el.err   = e;
    elems_due.push_back(el);
  endtask

  // Expand one compute word into the row-major result matrix, or a lone error word on a size mismatch
  task automatic walk_result_matrix();
    logic [3:0]  nr, nc, inner;
    logic [31:0] acc;
    bit          skip;
    int          i, j, k;
    skip = 0;
    nr   = '0;
    nc   = '0;
    case (op_r)
      OP_ADD: begin
        if (a_rows_r != b_rows_r || a_cols_r != b_cols_r) begin
          queue_elem(3'd0, 3'd0, 32'd0, 1'b1, ERR_ADD);
          skip = 1;
        end else begin
          nr = saturate(a_rows_r);
          nc = saturate(a_cols_r);
        end
      end
      OP_PRODUCT: begin
        if (a_cols_r != b_rows_r) begin
          queue_elem(3'd0, 3'd0, 32'd0, 1'b1, ERR_PRODUCT);
          skip = 1;
        end else begin
          nr = saturate(a_rows_r);
          nc = saturate(b_cols_r);
        end
      end
      OP_SCALE: begin
        nr = saturate(b_rows_r);
        nc = saturate(b_cols_r);
      end
      default: skip = 1;
    endcase
    inner = saturate(a_cols_r);
    if (!skip) begin
      for (i = 0; i < nr; i++) begin
        for (j = 0; j < nc; j++) begin
          acc = '0;
          case (op_r)
            OP_ADD:     acc = a_store[i*MAX_DIM+j] + b_store[i*MAX_DIM+j];
            OP_PRODUCT: begin
              for (k = 0; k < inner; k++)
                acc = acc + a_store[i*MAX_DIM+k] * b_store[k*MAX_DIM+j];
            end
            default:    acc = scale_r * b_store[i*MAX_DIM+j];
          endcase
          queue_elem(i[2:0], j[2:0], acc, (i + 1 == nr) && (j + 1 == nc), ERR_NONE);
        end
      end
    end
  endtask

  // Compare one accepted result word with the oldest expectation
  task automatic check_result();
    result_elem_t want;
    if (elems_due.size() == 0) begin
      $error("unexpected result word: out_row %0d out_col %0d out_value %h",
             m_tdata[2:0], m_tdata[5:3], m_tdata[37:6]);
      n_mismatch++;
    end else begin
      want = elems_due.pop_front();
      n_checked++;
      if (want.err != ERR_NONE) n_err++;
      if (m_tdata[2:0] !== want.row) begin
        $error("out_row: expected %0d, got %0d", want.row, m_tdata[2:0]);
        n_mismatch++;
      end
      if (m_tdata[5:3] !== want.col) begin
        $error("out_col: expected %0d, got %0d", want.col, m_tdata[5:3]);
        n_mismatch++;
      end
      if (m_tdata[37:6] !== want.value) begin
        $error("out_value: expected %h, got %h", want.value, m_tdata[37:6]);
        n_mismatch++;
      end
      if (m_tlast !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, m_tlast);
        n_mismatch++;
      end
      if (m_tuser !== want.err) begin
        $error("error: expected %0d, got %0d", want.err, m_tuser);
        n_mismatch++;
      end
    end
  endtask

  // Follow all three channels at each edge; publish counts as registers
  always @(posedge clk) begin
    if (rst) begin
      op_r     = OP_PRODUCT;
      a_rows_r = 4'd8;
      a_cols_r = 4'd8;
      b_rows_r = 4'd8;
      b_cols_r = 4'd8;
      scale_r  = 32'd1;
      elems_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_OPERATION: op_r     = cfg_data[1:0];
          CFG_A_ROWS:    a_rows_r = cfg_data[3:0];
          CFG_A_COLS:    a_cols_r = cfg_data[3:0];
          CFG_B_ROWS:    b_rows_r = cfg_data[3:0];
          CFG_B_COLS:    b_cols_r = cfg_data[3:0];
          CFG_SCALE:     scale_r  = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        case (s_tuser)
          MODE_LOAD_A:  a_store[{s_tdata[2:0], s_tdata[5:3]}] = s_tdata[37:6];
          MODE_LOAD_B:  b_store[{s_tdata[2:0], s_tdata[5:3]}] = s_tdata[37:6];
          MODE_COMPUTE: walk_result_matrix();
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) check_result();
    end
    mismatches  <= n_mismatch;
    pending     <= elems_due.size();
    checked     <= n_checked;
    error_words <= n_err;
  end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the integer matrix engine. A directed opening hits
// the value extremes, every operation, size mismatches, empty and saturated
// sizes and the unused codes; random phases follow, each with fresh register
// settings, element loads and compute words, under changing idle patterns.
// ----------------------------------------------------------------------------
module tb_top;
  import ima_pkg::*;

  localparam int ITEM_TARGET    = 360;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE         = 16;
  localparam int GAP_CAP        = 30;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam logic [2:0] CFG_UNUSED  = 3'd7;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata   = '0;
  logic [1:0]  s_tuser   = '0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [39:0] m_tdata;
  logic        m_tlast;
  logic [1:0]  m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data  = '0;

  int mismatches, pending, checked, error_words;

  // Mirror of the registers, used to know which store entries a run reads
  logic [1:0]  cur_op = OP_PRODUCT;
  logic [3:0]  cur_ar = 4'd8, cur_ac = 4'd8, cur_br = 4'd8, cur_bc = 4'd8;
  bit          written [2*DEPTH];
  int          entries_read[$];

  idle_mode_t  idle_mode   = IDLE_NONE;
  int          items_sent  = 0;
  int          computes    = 0;
  int          settings    = 0;
  int          stall_run   = 0;
  int          quiet       = 0;

  integer_matrix_arithmetic uut (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tlast, .m_tuser,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  ima_checker result_check (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tlast, .m_tuser,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .mismatches, .pending, .checked, .error_words
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int send_pct();
    case (idle_mode)
      IDLE_SENDER: return 78;
      IDLE_BOTH:   return 38;
      default:     return 0;
    endcase
  endfunction

  function automatic int recv_pct();
    case (idle_mode)
      IDLE_RECEIVER: return 78;
      IDLE_BOTH:     return 38;
      default:       return 0;
    endcase
  endfunction

  // Stall the result side at random, with each run of stalls capped by GAP_CAP
  always @(posedge clk) begin
    if (rst) begin
      m_tready  <= 1'b0;
      stall_run <= 0;
    end else if (stall_run < GAP_CAP && $urandom_range(99) < recv_pct()) begin
      m_tready  <= 1'b0;
      stall_run <= stall_run + 1;
    end else begin
      m_tready  <= 1'b1;
      stall_run <= 0;
    end
  end

  // Watchdog: count cycles in which no channel moves a word
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic [3:0] saturate(input logic [3:0] d);
    return (d > 4'd8) ? 4'd8 : d;
  endfunction

  function automatic logic [31:0] rand_value();
    case ($urandom_range(15))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // Mostly small sizes; now and then empty, full or above the store size
  function automatic logic [3:0] pick_size();
    int r;
    r = $urandom_range(99);
    if (r < 4)  return 4'd0;
    if (r < 12) return 4'($urandom_range(15, 8));
    return 4'($urandom_range(4, 1));
  endfunction

  // Drive one input word and hold it until accepted
  task automatic push_word(input logic [1:0] md, input logic [2:0] r, input logic [2:0] c,
                           input logic [31:0] v);
    int gap;
    gap = 0;
    while (gap < GAP_CAP && $urandom_range(99) < send_pct()) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, v, c, r};
    s_tuser  <= md;
    do @(posedge clk); while (!s_tready);
    if (md != MODE_UNUSED) items_sent++;
    if (md == MODE_COMPUTE) computes++;
    if (md == MODE_LOAD_A) written[{r, c}] = 1'b1;
    if (md == MODE_LOAD_B) written[DEPTH + {r, c}] = 1'b1;
  endtask

  // Entry code: bit 6 selects B, bits 5:3 row, bits 2:0 col
  task automatic push_entry(input int code, input logic [31:0] v);
    push_word(code[6] ? MODE_LOAD_B : MODE_LOAD_A, code[5:3], code[2:0], v);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Write every register; upper data bits are sometimes junk the block must drop
  task automatic set_config(input logic [1:0] op, input logic [3:0] ar, input logic [3:0] ac,
                            input logic [3:0] br, input logic [3:0] bc,
                            input logic [31:0] sf, input bit poke_unused);
    logic [31:0] junk;
    junk = ($urandom_range(1)) ? $urandom() : 32'd0;
    write_reg(CFG_OPERATION, {junk[31:2], op});
    write_reg(CFG_A_ROWS,    {junk[31:4], ar});
    write_reg(CFG_A_COLS,    {junk[31:4], ac});
    write_reg(CFG_B_ROWS,    {junk[31:4], br});
    write_reg(CFG_B_COLS,    {junk[31:4], bc});
    write_reg(CFG_SCALE,     sf);
    if (poke_unused) write_reg(CFG_UNUSED, $urandom());
    cfg_valid <= 1'b0;
    cur_op = op;
    cur_ar = ar;
    cur_ac = ac;
    cur_br = br;
    cur_bc = bc;
    settings++;
  endtask

  // List the store entries that a compute word reads under the current settings
  function automatic void collect_reads();
    logic [3:0] nr, nc, inner;
    int i, j, k;
    entries_read.delete();
    case (cur_op)
      OP_ADD: begin
        if (cur_ar == cur_br && cur_ac == cur_bc) begin
          nr = saturate(cur_ar);
          nc = saturate(cur_ac);
          for (i = 0; i < nr; i++)
            for (j = 0; j < nc; j++) begin
              entries_read.push_back(i*MAX_DIM + j);
              entries_read.push_back(DEPTH + i*MAX_DIM + j);
            end
        end
      end
      OP_PRODUCT: begin
        nr    = saturate(cur_ar);
        nc    = saturate(cur_bc);
        inner = saturate(cur_ac);
        if (cur_ac == cur_br && nr != 0 && nc != 0) begin
          for (i = 0; i < nr; i++)
            for (k = 0; k < inner; k++) entries_read.push_back(i*MAX_DIM + k);
          for (k = 0; k < inner; k++)
            for (j = 0; j < nc; j++) entries_read.push_back(DEPTH + k*MAX_DIM + j);
        end
      end
      OP_SCALE: begin
        nr = saturate(cur_br);
        nc = saturate(cur_bc);
        for (i = 0; i < nr; i++)
          for (j = 0; j < nc; j++) entries_read.push_back(DEPTH + i*MAX_DIM + j);
      end
      default: ;
    endcase
  endfunction

  // Wait until every owed result has come, then let the pipeline drain
  task automatic settle();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Fill entries the run reads that were never written, refresh a few, compute
  task automatic run_compute(input int reloads);
    collect_reads();
    foreach (entries_read[n])
      if (!written[entries_read[n]]) push_entry(entries_read[n], rand_value());
    if (entries_read.size() > 0)
      repeat (reloads)
        push_entry(entries_read[$urandom_range(entries_read.size() - 1)], rand_value());
    push_word(MODE_COMPUTE, 3'($urandom()), 3'($urandom()), $urandom());
    if ($urandom_range(99) < 20)
      push_word(MODE_COMPUTE, 3'($urandom()), 3'($urandom()), $urandom());
    s_tvalid <= 1'b0;
    settle();
  endtask

  initial begin : stimulus
    logic [1:0] op;
    logic [3:0] ar, ac, br, bc;
    int         seq, n;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Add at 1x1 with wrap-around; load the far corner with extremes
    set_config(OP_ADD, 4'd1, 4'd1, 4'd1, 4'd1, 32'd1, 1'b0);
    push_word(MODE_LOAD_A, 3'd0, 3'd0, 32'h7FFF_FFFF);
    push_word(MODE_LOAD_B, 3'd0, 3'd0, 32'h0000_0001);
    push_word(MODE_LOAD_A, 3'd7, 3'd7, 32'h8000_0000);
    push_word(MODE_LOAD_B, 3'd7, 3'd7, 32'hFFFF_FFFF);
    push_word(MODE_UNUSED, 3'd5, 3'd2, 32'hA5A5_5A5A);
    run_compute(0);

    // Scale by the most negative factor
    set_config(OP_SCALE, 4'd1, 4'd1, 4'd1, 4'd1, 32'h8000_0000, 1'b0);
    push_word(MODE_LOAD_B, 3'd0, 3'd0, 32'hFFFF_FFFF);
    run_compute(0);

    // Product with a row count above the store size
    set_config(OP_PRODUCT, 4'd9, 4'd1, 4'd1, 4'd2, 32'd1, 1'b0);
    run_compute(0);

    // Mismatches judged on raw register values
    set_config(OP_ADD, 4'd9, 4'd1, 4'd8, 4'd1, 32'd1, 1'b0);
    run_compute(0);
    set_config(OP_PRODUCT, 4'd2, 4'd12, 4'd8, 4'd2, 32'd1, 1'b0);
    run_compute(0);

    // Empty result, zero inner size, unused operation and register
    set_config(OP_ADD, 4'd0, 4'd3, 4'd0, 4'd3, 32'd1, 1'b0);
    run_compute(0);
    set_config(OP_PRODUCT, 4'd2, 4'd0, 4'd0, 4'd2, 32'd1, 1'b0);
    run_compute(0);
    set_config(OP_UNUSED, 4'd15, 4'd15, 4'd15, 4'd15, 32'h7FFF_FFFF, 1'b1);
    run_compute(0);

    // Random phases, rotating through the idle patterns
    seq = 0;
    while (items_sent < ITEM_TARGET) begin
      idle_mode = idle_mode_t'(seq % 4);
      seq++;
      op = ($urandom_range(99) < 5) ? OP_UNUSED : 2'($urandom_range(2));
      ar = pick_size();
      ac = pick_size();
      br = pick_size();
      bc = pick_size();
      if ($urandom_range(99) < 85) begin
        if (op == OP_ADD) begin
          br = ar;
          bc = ac;
        end else if (op == OP_PRODUCT) begin
          br = ac;
        end
      end
      set_config(op, ar, ac, br, bc, rand_value(), $urandom_range(99) < 5);
      // Noise: ignored words and stray loads anywhere in the stores
      if ($urandom_range(99) < 15) begin
        repeat ($urandom_range(3, 1)) begin
          n = $urandom_range(2);
          if (n == 0)
            push_word(MODE_UNUSED, 3'($urandom()), 3'($urandom()), $urandom());
          else
            push_word(n == 1 ? MODE_LOAD_A : MODE_LOAD_B, 3'($urandom()), 3'($urandom()),
                      rand_value());
        end
      end
      run_compute($urandom_range(6, 1));
    end

    // Drain and give the verdict
    idle_mode = IDLE_NONE;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4 * SETTLE) @(posedge clk);
    $display("Covered %0d input words, %0d of them compute words, over %0d register settings",
             items_sent, computes, settings);
    $display("and four idle patterns; %0d result words checked, %0d carrying a size error.",
             checked, error_words);
    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
